// ----- hdl/gsob_pkg.sv -----
// ----------------------------------------------------------------------------
// gsob_pkg
// Shared types and constants of the gray Sobel edge stream.
// ----------------------------------------------------------------------------
package gsob_pkg;

  localparam int PIX_W      = 8;
  localparam int CRD_W      = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int PROD_W     = 24;
  localparam int MIN_SIZE   = 3;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  // BT.601 luma weights, unsigned Q0.16, summing to 65536
  localparam logic [15:0] GRAY_COEF_R = 16'd19595;
  localparam logic [15:0] GRAY_COEF_G = 16'd38470;
  localparam logic [15:0] GRAY_COEF_B = 16'd7471;

  localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_magnitude;
    logic [CRD_W-1:0] centre_row;
    logic [CRD_W-1:0] centre_column;
    logic             frame_done;
  } result_t;

  // one classified pixel on its way from the front to the back
  typedef struct packed {
    pixel_t           pixel;
    logic             emit;
    logic             done;
    logic [CRD_W-1:0] centre_row;
    logic [CRD_W-1:0] centre_column;
  } job_t;

endpackage

// ----- hdl/gsob_ram.sv -----
// ----------------------------------------------------------------------------
// gsob_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gsob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/gsob_front.sv -----
// ----------------------------------------------------------------------------
// gsob_front
// Accepts pixels, tracks the raster position and tags each pixel with its
// line buffer address, window centre and whether it yields a result.
// ----------------------------------------------------------------------------
module gsob_front
  import gsob_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [CFG_DATA_W-1:0]        frame_width,
  input  logic [CFG_DATA_W-1:0]        frame_height,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pixel_t                       in_data,
  input  logic                         q_full,
  output logic                         push,
  output job_t                         push_job,
  output logic [$clog2(MAX_WIDTH)-1:0] push_addr
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  // compare widths hold the size limit and position + 1
  localparam int WC_W  = ((CFG_DATA_W > COL_W) ? CFG_DATA_W : COL_W) + 1;
  localparam int HC_W  = ((CFG_DATA_W > ROW_W) ? CFG_DATA_W : ROW_W) + 1;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WC_W-1:0]  fw_ext, eff_w;
  logic [HC_W-1:0]  fh_ext, eff_h;
  logic             accept;
  logic             last_col;
  logic             last_row;

  assign fw_ext = WC_W'(frame_width);
  assign fh_ext = HC_W'(frame_height);

  always_comb begin
    priority if (fw_ext < WC_W'(MIN_SIZE)) begin
      eff_w = WC_W'(MIN_SIZE);
    end else if (fw_ext > WC_W'(MAX_WIDTH)) begin
      eff_w = WC_W'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    priority if (fh_ext < HC_W'(MIN_SIZE)) begin
      eff_h = HC_W'(MIN_SIZE);
    end else if (fh_ext > HC_W'(MAX_HEIGHT)) begin
      eff_h = HC_W'(MAX_HEIGHT);
    end else begin
      eff_h = fh_ext;
    end
  end

  assign last_col = (WC_W'(col_r) + WC_W'(1)) >= eff_w;
  assign last_row = (HC_W'(row_r) + HC_W'(1)) >= eff_h;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign push                   = accept;
  assign push_addr              = col_r;
  assign push_job.pixel         = in_data;
  assign push_job.emit          = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign push_job.done          = last_col && last_row;
  assign push_job.centre_row    = CRD_W'(row_r - ROW_W'(1));
  assign push_job.centre_column = CRD_W'(col_r - COL_W'(1));

endmodule

// ----- hdl/gsob_queue.sv -----
// ----------------------------------------------------------------------------
// gsob_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module gsob_queue
  import gsob_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_pop;

  assign full      = count_r == CNT_W'(DEPTH);
  assign not_empty = count_r != '0;
  assign do_pop    = pop && not_empty;
  assign head_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/gsob_back.sv -----
// ----------------------------------------------------------------------------
// gsob_back
// Gray conversion, line buffers, 3x3 window and Sobel magnitude.
// Three stages: products + buffer read, gray + window, magnitude register.
// ----------------------------------------------------------------------------
module gsob_back
  import gsob_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  job_t                         q_job,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_addr,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output result_t                      out_data
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int SUM_W  = PIX_W + 2;

  logic en;

  // stage 1
  logic              s1_valid_r, s1_valid_nxt;
  job_t              s1_job_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [PROD_W-1:0] s1_pr_r, s1_pg_r, s1_pb_r;
  logic [PIX_W-1:0]  two_back_rd, one_back_rd;

  // stage 2
  logic             s2_valid_r, s2_valid_nxt;
  logic             s2_emit_r, s2_done_r;
  logic [CRD_W-1:0] s2_row_r, s2_col_r;
  logic [PIX_W-1:0] s2_top_r, s2_mid_r, s2_bot_r;
  logic [PIX_W-1:0] s2_l0_r, s2_l1_r, s2_l2_r, s2_c0_r, s2_c2_r;
  logic [PIX_W-1:0] win_r [6];
  logic [PROD_W-1:0] gray_sum;
  logic [PIX_W-1:0]  gray;
  logic              s2_load;

  // stage 3
  logic              out_valid_r, out_valid_nxt;
  result_t           out_data_r;
  logic [SUM_W-1:0]  gx_a, gx_b, gy_a, gy_b, gx_abs, gy_abs;
  logic [SUM_W:0]    mag;
  logic [PIX_W-1:0]  mag_sat;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_valid;

  // ---- stage 1: weight products, line buffer read ----
  assign s1_valid_nxt = en ? q_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_job_r  <= q_job;
      s1_addr_r <= q_addr;
      s1_pr_r   <= PROD_W'(q_job.pixel.red) * GRAY_COEF_R;
      s1_pg_r   <= PROD_W'(q_job.pixel.green) * GRAY_COEF_G;
      s1_pb_r   <= PROD_W'(q_job.pixel.blue) * GRAY_COEF_B;
    end
  end

  gsob_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_two_back (
    .clk   (clk),
    .we    (s2_load),
    .waddr (s1_addr_r),
    .wdata (one_back_rd),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (two_back_rd)
  );

  gsob_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_one_back (
    .clk   (clk),
    .we    (s2_load),
    .waddr (s1_addr_r),
    .wdata (gray),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (one_back_rd)
  );

  // ---- stage 2: gray value, buffer update, window shift ----
  assign s2_load  = en && s1_valid_r;
  assign gray_sum = s1_pr_r + s1_pg_r + s1_pb_r;
  assign gray     = gray_sum[PROD_W-1 -: PIX_W];

  assign s2_valid_nxt = en ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s2_valid_r <= s2_valid_nxt;
      if (s2_load) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= two_back_rd;
        win_r[4] <= one_back_rd;
        win_r[5] <= gray;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_emit_r <= s1_job_r.emit;
      s2_done_r <= s1_job_r.done;
      s2_row_r  <= s1_job_r.centre_row;
      s2_col_r  <= s1_job_r.centre_column;
      s2_top_r  <= two_back_rd;
      s2_mid_r  <= one_back_rd;
      s2_bot_r  <= gray;
      s2_l0_r   <= win_r[0];
      s2_l1_r   <= win_r[1];
      s2_l2_r   <= win_r[2];
      s2_c0_r   <= win_r[3];
      s2_c2_r   <= win_r[5];
    end
  end

  // ---- stage 3: |Gx| + |Gy| ----
  assign gx_a = SUM_W'(s2_top_r) + (SUM_W'(s2_mid_r) << 1) + SUM_W'(s2_bot_r);
  assign gx_b = SUM_W'(s2_l0_r) + (SUM_W'(s2_l1_r) << 1) + SUM_W'(s2_l2_r);
  assign gy_a = SUM_W'(s2_l2_r) + (SUM_W'(s2_c2_r) << 1) + SUM_W'(s2_bot_r);
  assign gy_b = SUM_W'(s2_l0_r) + (SUM_W'(s2_c0_r) << 1) + SUM_W'(s2_top_r);

  assign gx_abs  = (gx_a >= gx_b) ? gx_a - gx_b : gx_b - gx_a;
  assign gy_abs  = (gy_a >= gy_b) ? gy_a - gy_b : gy_b - gy_a;
  assign mag     = (SUM_W + 1)'(gx_abs) + (SUM_W + 1)'(gy_abs);
  assign mag_sat = (mag > (SUM_W + 1)'(MAG_MAX)) ? MAG_MAX : mag[PIX_W-1:0];

  assign out_valid_nxt = en ? (s2_valid_r && s2_emit_r) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.edge_magnitude <= mag_sat;
      out_data_r.centre_row     <= s2_row_r;
      out_data_r.centre_column  <= s2_col_r;
      out_data_r.frame_done     <= s2_done_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/gray_sobel_edge_stream.sv -----
// ----------------------------------------------------------------------------
// gray_sobel_edge_stream
// BGR pixel stream in, 3x3 Sobel edge magnitude of the gray image out.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one request per clock at full rate while
// in_stall is low. Each is turned into BT.601 gray, and for every pixel at
// row >= 2 and column >= 2 one result leaves for the window centre (row-1,
// column-1): |Gx|+|Gy| saturated to 255, the centre coordinates and a flag
// on the frame's last interior pixel. Border pixels produce nothing. The
// sustained rate is one pixel per clock while out_stall is low, set by the
// two line buffer RAMs, each read once and written once per pixel. Requests
// pass the queue, products and buffer read, gray and window, and magnitude.
// frame_width and frame_height are clamped to [3, MAX_WIDTH] and
// [3, MAX_HEIGHT]; change them only while the block is idle.
// ----------------------------------------------------------------------------
module gray_sobel_edge_stream
  import gsob_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pixel_t                in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int ENTRY_W = ADDR_W + $bits(job_t);

  logic [CFG_DATA_W-1:0] frame_width_r, frame_width_nxt;
  logic [CFG_DATA_W-1:0] frame_height_r, frame_height_nxt;

  logic              push, q_full, q_pop, q_valid;
  job_t              push_job, q_job;
  logic [ADDR_W-1:0] push_addr, q_addr;
  logic [ENTRY_W-1:0] head_entry;

  // ---- configuration registers ----
  assign cfg_ready = 1'b1;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          frame_width_nxt = cfg_data;
        end
        CFG_FRAME_HEIGHT: begin
          frame_height_nxt = cfg_data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  gsob_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job),
    .push_addr    (push_addr)
  );

  gsob_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_addr, push_job}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_data (head_entry)
  );

  assign q_addr = head_entry[ENTRY_W-1 -: ADDR_W];
  assign q_job  = head_entry[$bits(job_t)-1:0];

  gsob_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_addr    (q_addr),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gray Sobel edge stream.
// ----------------------------------------------------------------------------
// BGR pixel requests go in through a queue-fed driver and results come out
// through a monitor. On every accepted pixel a local copy of the gray
// conversion, the line buffers and the 3x3 window works out the edge result,
// if any, and queues it. The monitor compares each result field by field
// with the oldest queued one. Frame sizes change only at quiet points: at
// frame boundaries, or mid-frame as a shrink. The run covers the reset width,
// sizes clamped up to the minimum, a directed pattern frame and random frames
// under several idling mixes on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import gsob_pkg::*;

  localparam int LINE_DEPTH    = 2048;
  localparam int RANDOM_PIXELS = 1180;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;

  localparam pixel_t WHITE = '{default: 8'hFF};
  localparam pixel_t BLACK = '{default: 8'h00};

  typedef enum int {SHADE_NOISE, SHADE_FLAT, SHADE_BINARY, SHADE_RAMP} shade_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic    in_valid = 1'b0;
  logic    in_stall;
  pixel_t  in_data = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  result_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gray_sobel_edge_stream dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stimulus and expectation stores
  pixel_t  pending_pixels[$];
  result_t expected_edges[$];
  int      pixels_queued = 0;
  int      pixels_accepted = 0;
  int      error_count = 0;
  int      sender_idle_pct = 0;
  int      receiver_stall_pct = 0;
  pixel_t  flat_px = '0;

  // local copy of the block's configuration and state
  logic [CFG_DATA_W-1:0] frame_width_reg = FRAME_WIDTH_RST;
  logic [CFG_DATA_W-1:0] frame_height_reg = FRAME_HEIGHT_RST;
  logic [7:0]  gray_above2 [LINE_DEPTH] = '{default: 8'h00};
  logic [7:0]  gray_above1 [LINE_DEPTH] = '{default: 8'h00};
  logic [7:0]  kernel_cols [6] = '{default: 8'h00};
  int unsigned pos_col = 0;
  int unsigned pos_row = 0;

  function automatic int unsigned fit_size(int unsigned raw);
    if (raw < 3) return 3;
    if (raw > LINE_DEPTH) return LINE_DEPTH;
    return raw;
  endfunction

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic predict_edge(input pixel_t px);
    int unsigned w, h, gray, idx;
    int top, mid, bot, l0, l1, l2, c0, c2, gx, gy, mag;
    result_t res;
    w = fit_size(frame_width_reg);
    h = fit_size(frame_height_reg);
    gray = (19595 * int'(px.red) + 38470 * int'(px.green) + 7471 * int'(px.blue)) >> 16;
    idx = pos_col % LINE_DEPTH;
    top = int'(gray_above2[idx]);
    mid = int'(gray_above1[idx]);
    bot = int'(gray);
    gray_above2[idx] = mid[7:0];
    gray_above1[idx] = gray[7:0];
    if (pos_row >= 2 && pos_col >= 2) begin
      l0 = int'(kernel_cols[0]);
      l1 = int'(kernel_cols[1]);
      l2 = int'(kernel_cols[2]);
      c0 = int'(kernel_cols[3]);
      c2 = int'(kernel_cols[5]);
      gx = (top + 2 * mid + bot) - (l0 + 2 * l1 + l2);
      gy = (l2 + 2 * c2 + bot) - (l0 + 2 * c0 + top);
      mag = iabs(gx) + iabs(gy);
      if (mag > 255) mag = 255;
      res.edge_magnitude = mag[7:0];
      res.centre_row     = CRD_W'(pos_row - 1);
      res.centre_column  = CRD_W'(pos_col - 1);
      res.frame_done     = (pos_row + 1 >= h) && (pos_col + 1 >= w);
      expected_edges.push_back(res);
    end
    kernel_cols[0] = kernel_cols[3];
    kernel_cols[1] = kernel_cols[4];
    kernel_cols[2] = kernel_cols[5];
    kernel_cols[3] = top[7:0];
    kernel_cols[4] = mid[7:0];
    kernel_cols[5] = bot[7:0];
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_edge(in_data);
        pixels_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pixels.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_edges.size() == 0) begin
          $error("unexpected result: row %0d column %0d", out_data.centre_row,
                 out_data.centre_column);
          error_count++;
        end else begin
          want = expected_edges.pop_front();
          if (out_data.edge_magnitude !== want.edge_magnitude) begin
            $error("edge_magnitude: expected %0d, got %0d", want.edge_magnitude,
                   out_data.edge_magnitude);
            error_count++;
          end
          if (out_data.centre_row !== want.centre_row) begin
            $error("centre_row: expected %0d, got %0d", want.centre_row,
                   out_data.centre_row);
            error_count++;
          end
          if (out_data.centre_column !== want.centre_column) begin
            $error("centre_column: expected %0d, got %0d", want.centre_column,
                   out_data.centre_column);
            error_count++;
          end
          if (out_data.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done,
                   out_data.frame_done);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
    end
  end

  // watchdog: cycles without any accepted request on any channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** gray_sobel_edge_stream: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) frame_width_reg = value;
    else frame_height_reg = value;
  endtask

  task automatic set_frame(input int unsigned width, input int unsigned height);
    write_register(CFG_FRAME_WIDTH, CFG_DATA_W'(width));
    write_register(CFG_FRAME_HEIGHT, CFG_DATA_W'(height));
  endtask

  // wait for every pixel to be taken and every result to come back,
  // then let the pipeline empty of border pixels
  task automatic wait_quiet();
    while (pixels_accepted != pixels_queued || expected_edges.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
      default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
    endcase
  endtask

  function automatic pixel_t make_pixel(shade_e shade, int unsigned row,
                                        int unsigned col);
    pixel_t px;
    logic [7:0] v;
    case (shade)
      SHADE_FLAT:   px = flat_px;
      SHADE_BINARY: px = $urandom_range(1, 0) ? WHITE : BLACK;
      SHADE_RAMP: begin
        v = 8'((col * 37 + row * 11) & 8'hFF);
        px = '{blue: v, green: v, red: v};
      end
      default: begin
        px.blue  = 8'($urandom_range(255, 0));
        px.green = 8'($urandom_range(255, 0));
        px.red   = 8'($urandom_range(255, 0));
      end
    endcase
    return px;
  endfunction

  function automatic pixel_t pattern_pixel(int unsigned row, int unsigned col);
    case (row)
      0: return WHITE;
      1: begin
        case (col)
          2: return '{blue: 8'h00, green: 8'h00, red: 8'hFF};
          3: return '{blue: 8'h00, green: 8'hFF, red: 8'h00};
          4: return '{blue: 8'hFF, green: 8'h00, red: 8'h00};
          default: return WHITE;
        endcase
      end
      2: return BLACK;
      3: return col[0] ? WHITE : BLACK;
      default: return '{default: 8'h80};
    endcase
  endfunction

  task automatic push_pixels(input int count, input int unsigned width,
                             input shade_e shade);
    for (int i = 0; i < count; i++) begin
      pending_pixels.push_back(make_pixel(shade, i / width, i % width));
      pixels_queued++;
    end
  endtask

  // number of pixels that bring the raster position back to the frame start
  function automatic int pixels_to_frame_end(int unsigned row, int unsigned col,
                                             int unsigned w, int unsigned h);
    int n;
    n = 0;
    do begin
      n++;
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    end while (row != 0 || col != 0);
    return n;
  endfunction

  initial begin
    int unsigned w_raw, h_raw, w_eff, h_eff;
    int random_pixels, segment, frames, part;
    shade_e shade;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset width: finish row 0 of a 640-wide frame and step into row 1,
    // then shrink below the minimum and run the 3x3 remainder of the frame
    set_idling(0);
    push_pixels(640 + 1, 640, SHADE_NOISE);
    wait_quiet();
    set_frame(2, 1);
    push_pixels(pixels_to_frame_end(pos_row, pos_col, fit_size(frame_width_reg),
                                    fit_size(frame_height_reg)), 3, SHADE_NOISE);
    wait_quiet();

    // directed frame: saturation, flat areas, single-channel extremes
    set_frame(5, 5);
    for (int i = 0; i < 25; i++) begin
      pending_pixels.push_back(pattern_pixel(i / 5, i % 5));
      pixels_queued++;
    end
    wait_quiet();

    random_pixels = 0;
    segment = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      set_idling(segment);
      case ($urandom_range(9, 0))
        0: w_raw = $urandom_range(2, 0);
        1: w_raw = $urandom_range(64, 25);
        default: w_raw = $urandom_range(24, 3);
      endcase
      h_raw = ($urandom_range(7, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(8, 3);
      w_eff = fit_size(w_raw);
      h_eff = fit_size(h_raw);
      set_frame(w_raw, h_raw);
      frames = $urandom_range(2, 1);
      for (int f = 0; f < frames; f++) begin
        shade = shade_e'($urandom_range(3, 0));
        flat_px = make_pixel(SHADE_NOISE, 0, 0);
        if ($urandom_range(4, 0) == 0) begin
          // stop mid-frame, shrink the frame, then finish it
          part = $urandom_range(w_eff * h_eff - 1, 1);
          push_pixels(part, w_eff, shade);
          wait_quiet();
          w_raw = $urandom_range(w_eff, 0);
          h_raw = $urandom_range(h_eff, 0);
          set_frame(w_raw, h_raw);
          w_eff = fit_size(w_raw);
          h_eff = fit_size(h_raw);
          frames = f + 1;
          part += pixels_to_frame_end(pos_row, pos_col, w_eff, h_eff);
          push_pixels(part - random_pixels + random_pixels
                      - (part - pixels_to_frame_end(pos_row, pos_col, w_eff, h_eff)),
                      w_eff, shade);
          random_pixels += part;
        end else begin
          push_pixels(w_eff * h_eff, w_eff, shade);
          random_pixels += w_eff * h_eff;
        end
      end
      wait_quiet();
      segment++;
    end

    wait_quiet();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_edges.size() == 0) begin
      $display("** gray_sobel_edge_stream: PASSED **");
    end else begin
      $display("** gray_sobel_edge_stream: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/gsob_pkg.sv
hdl/gsob_ram.sv
hdl/gsob_front.sv
hdl/gsob_queue.sv
hdl/gsob_back.sv
hdl/gray_sobel_edge_stream.sv
tb/tb_top.sv
